// File: design/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg: shared definitions of the fixed-partition fit allocator
// Sizes, field widths, codes and the types that pass between the front,
// the command queue and the back of the allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

   localparam int BLOCKS      = 64;
   localparam int SIZE_WIDTH  = 16;
   localparam int IDX_W       = $clog2(BLOCKS);
   localparam int CNT_W       = $clog2(BLOCKS + 1);

   localparam int MODE_W      = 2;
   localparam int AMOUNT_W    = 16;
   localparam int STATUS_W    = 3;
   localparam int INDEX_W     = 6;
   localparam int FRAG_W      = 16;
   localparam int REQNO_W     = 16;
   localparam int SUM_W       = 22;
   localparam int ADD_W       = ((SUM_W > SIZE_WIDTH) ? SUM_W : SIZE_WIDTH) + 1;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   localparam int POLICY_W    = 2;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_IDX_W   = CSR_ADDR_W - 2;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_FIT_POLICY = 1'd0;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Input mode codes.
   localparam logic [MODE_W-1:0] MODE_LOAD    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REQUEST = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd2;

   // Fit policy codes; the fourth code behaves as first fit.
   localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
   localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
   localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_LOADED    = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_CLEARED   = 3'd4;

   typedef enum logic [1:0] {
      OP_LOAD    = 2'd0,
      OP_REQUEST = 2'd1,
      OP_CLEAR   = 2'd2
   } op_type;

   typedef struct packed {
      op_type                op;
      logic [SIZE_WIDTH-1:0] amount;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [INDEX_W-1:0]  block_index;
      logic [FRAG_W-1:0]   fragment;
      logic [REQNO_W-1:0]  request_number;
      logic [SUM_W-1:0]    total_fragment;
   } rsp_type;

endpackage

// File: design/fpfa_channels.sv
// ----------------------------------------------------------------------------
// fpfa channels: valid/ready channel interfaces of the allocator
// The request channel carries mode and amount, the response channel the
// fields of one result.
// ----------------------------------------------------------------------------
interface fpfa_req_if;
   logic                           valid;
   logic                           ready;
   logic [fpfa_pkg::MODE_W-1:0]    mode;
   logic [fpfa_pkg::AMOUNT_W-1:0]  amount;

   modport source (output valid, output mode, output amount, input ready);
   modport sink   (input valid, input mode, input amount, output ready);
endinterface

interface fpfa_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [fpfa_pkg::STATUS_W-1:0]  status;
   logic [fpfa_pkg::INDEX_W-1:0]   block_index;
   logic [fpfa_pkg::FRAG_W-1:0]    fragment;
   logic [fpfa_pkg::REQNO_W-1:0]   request_number;
   logic [fpfa_pkg::SUM_W-1:0]     total_fragment;

   modport source (output valid, output status, output block_index, output fragment,
                   output request_number, output total_fragment, input ready);
   modport sink   (input valid, input status, input block_index, input fragment,
                   input request_number, input total_fragment, output ready);
endinterface

// File: design/fixed_partition_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core: fixed-partition fit allocator
// Result path: a load or clear result passes the front stage, the queue and
// the result register; a request result also waits for the scan, which covers
// all loaded blocks, or those up to the first adequate one under first fit.
// Throughput: loads and clears one per cycle unless results stall; a request
// holds the back through its one-block-per-cycle table scan and finish state.
// Reset clears taken flags, counters, policy and queue at once; no sweep.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_core (
   input  logic                              clock,
   input  logic                              reset,
   fpfa_req_if.sink                          req_ch,
   fpfa_rsp_if.source                        rsp_ch,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [fpfa_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [fpfa_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [fpfa_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   // The fit policy register. It sits at byte address 0; the low two address
   // bits select a byte lane and are not decoded.
   logic [fpfa_pkg::POLICY_W-1:0]    policy_ff;
   logic [fpfa_pkg::CSR_IDX_W-1:0]   csr_index;
   logic                             csr_write;

   // Front-to-queue and queue-to-back connections.
   logic                             q_push, q_pop;
   fpfa_pkg::cmd_type                push_cmd, pop_cmd;
   fpfa_pkg::queue_status_type       q_status;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[fpfa_pkg::CSR_ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Reads return the policy for its address and zero for anything else.
   assign csr_prdata = (csr_index == fpfa_pkg::CSR_REG_FIT_POLICY)
                       ? fpfa_pkg::CSR_DATA_W'(policy_ff) : '0;

   // Writes to addresses beyond the register list complete and are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         policy_ff <= fpfa_pkg::POLICY_FIRST;
      end else if (csr_write && (csr_index == fpfa_pkg::CSR_REG_FIT_POLICY)) begin
         policy_ff <= csr_pwdata[fpfa_pkg::POLICY_W-1:0];
      end
   end

   // The front classifies each transfer and stages it for the queue.
   fpfa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .q_status (q_status),
      .q_push   (q_push),
      .q_cmd    (push_cmd)
   );

   // The queue lets the front keep taking transfers while a scan runs.
   fpfa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .pop_cmd  (pop_cmd),
      .status   (q_status)
   );

   // The back owns the table and the counters and drives the result register,
   // which must be empty or handing over its result before a command is taken.
   fpfa_back u_back (
      .clock    (clock),
      .reset    (reset),
      .policy   (policy_ff),
      .q_status (q_status),
      .q_cmd    (pop_cmd),
      .q_pop    (q_pop),
      .rsp_ch   (rsp_ch)
   );

endmodule

// File: design/fpfa_front.sv
// ----------------------------------------------------------------------------
// fpfa_front: request intake and classification
// Takes request transfers, turns the mode into a command, drops the unused
// mode and hands commands to the queue through one register stage.
// ----------------------------------------------------------------------------
module fpfa_front (
   input  logic                       clock,
   input  logic                       reset,
   fpfa_req_if.sink                   req_ch,
   input  fpfa_pkg::queue_status_type q_status,
   output logic                       q_push,
   output fpfa_pkg::cmd_type          q_cmd
);

   logic              stage_valid_ff, stage_valid_in;
   fpfa_pkg::cmd_type stage_cmd_ff, stage_cmd_in;
   logic              accept;

   assign q_push       = stage_valid_ff && !q_status.full;
   assign q_cmd        = stage_cmd_ff;
   assign req_ch.ready = !stage_valid_ff || !q_status.full;
   assign accept       = req_ch.valid && req_ch.ready;

   always_comb begin
      stage_valid_in = stage_valid_ff && !q_push;
      stage_cmd_in   = stage_cmd_ff;
      if (accept) begin
         stage_cmd_in.amount = fpfa_pkg::SIZE_WIDTH'(req_ch.amount);
         case (req_ch.mode)
            fpfa_pkg::MODE_LOAD: begin
               stage_cmd_in.op = fpfa_pkg::OP_LOAD;
               stage_valid_in  = 1'b1;
            end
            fpfa_pkg::MODE_REQUEST: begin
               stage_cmd_in.op = fpfa_pkg::OP_REQUEST;
               stage_valid_in  = 1'b1;
            end
            fpfa_pkg::MODE_CLEAR: begin
               stage_cmd_in.op = fpfa_pkg::OP_CLEAR;
               stage_valid_in  = 1'b1;
            end
            default: begin
               // The unused mode is taken and has no effect.
               stage_valid_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
      stage_cmd_ff <= stage_cmd_in;
   end

endmodule

// File: design/fpfa_queue.sv
// ----------------------------------------------------------------------------
// fpfa_queue: command queue between front and back
// A small first-in first-out buffer of classified commands.
// ----------------------------------------------------------------------------
module fpfa_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fpfa_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output fpfa_pkg::cmd_type          pop_cmd,
   output fpfa_pkg::queue_status_type status
);

   fpfa_pkg::cmd_type                 entry_ff [fpfa_pkg::QUEUE_DEPTH];
   logic [fpfa_pkg::QPTR_W-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [fpfa_pkg::QCNT_W-1:0]       count_ff;
   logic                              do_push, do_pop;

   function automatic logic [fpfa_pkg::QPTR_W-1:0] next_ptr(
      input logic [fpfa_pkg::QPTR_W-1:0] ptr);
      if (ptr == fpfa_pkg::QPTR_W'(fpfa_pkg::QUEUE_DEPTH - 1)) begin
         return '0;
      end
      return ptr + 1'b1;
   endfunction

   assign status.full  = (count_ff == fpfa_pkg::QCNT_W'(fpfa_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_cmd      = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= next_ptr(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= next_ptr(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: design/fpfa_back.sv
// ----------------------------------------------------------------------------
// fpfa_back: allocation engine
// Holds the block table, the taken flags and the counters, executes one
// command at a time and scans the table one block per cycle for a fit.
// ----------------------------------------------------------------------------
module fpfa_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [fpfa_pkg::POLICY_W-1:0]     policy,
   input  fpfa_pkg::queue_status_type        q_status,
   input  fpfa_pkg::cmd_type                 q_cmd,
   output logic                              q_pop,
   fpfa_rsp_if.source                        rsp_ch
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

   state_type                          state_ff, state_in;
   logic [fpfa_pkg::SIZE_WIDTH-1:0]    mem [fpfa_pkg::BLOCKS];
   logic [fpfa_pkg::SIZE_WIDTH-1:0]    rd_data_ff;
   logic [fpfa_pkg::IDX_W-1:0]         rd_addr;
   logic                               mem_we;

   logic [fpfa_pkg::BLOCKS-1:0]        taken_ff, taken_in;
   logic [fpfa_pkg::CNT_W-1:0]         count_ff, count_in;
   logic [fpfa_pkg::REQNO_W-1:0]       reqcnt_ff, reqcnt_in;
   logic [fpfa_pkg::SUM_W-1:0]         sum_ff, sum_in;

   logic [fpfa_pkg::REQNO_W-1:0]       reqno_ff, reqno_in;
   logic [fpfa_pkg::SIZE_WIDTH-1:0]    amount_ff, amount_in;
   logic [fpfa_pkg::IDX_W-1:0]         scan_idx_ff, scan_idx_in;
   logic                               found_ff, found_in;
   logic [fpfa_pkg::IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [fpfa_pkg::SIZE_WIDTH-1:0]    best_frag_ff, best_frag_in;

   logic                               out_valid_ff, out_valid_in;
   fpfa_pkg::rsp_type                  out_ff, out_in;

   logic                               out_free;
   logic                               cand_ok, cand_take, first_fit, last_block;
   logic [fpfa_pkg::SIZE_WIDTH-1:0]    cand_frag;
   logic [fpfa_pkg::ADD_W-1:0]         sum_ext;
   logic [fpfa_pkg::SUM_W-1:0]         sum_sat;

   assign out_free = !out_valid_ff || rsp_ch.ready;

   // Candidate evaluation on the block read in the previous cycle.
   assign cand_ok   = !taken_ff[scan_idx_ff] && (rd_data_ff >= amount_ff);
   assign cand_frag = rd_data_ff - amount_ff;
   assign first_fit = (policy != fpfa_pkg::POLICY_BEST) && (policy != fpfa_pkg::POLICY_WORST);
   assign cand_take = cand_ok && (!found_ff
                      || ((policy == fpfa_pkg::POLICY_BEST) && (cand_frag < best_frag_ff))
                      || ((policy == fpfa_pkg::POLICY_WORST) && (cand_frag > best_frag_ff)));
   assign last_block = ((fpfa_pkg::CNT_W'(scan_idx_ff) + 1'b1) == count_ff);

   assign sum_ext = fpfa_pkg::ADD_W'(sum_ff) + fpfa_pkg::ADD_W'(best_frag_ff);
   assign sum_sat = (sum_ext > fpfa_pkg::ADD_W'(fpfa_pkg::SUM_MAX)) ? fpfa_pkg::SUM_MAX
                                                                   : sum_ext[fpfa_pkg::SUM_W-1:0];

   always_comb begin
      state_in     = state_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      rd_addr      = scan_idx_ff;
      taken_in     = taken_ff;
      count_in     = count_ff;
      reqcnt_in    = reqcnt_ff;
      sum_in       = sum_ff;
      reqno_in     = reqno_ff;
      amount_in    = amount_ff;
      scan_idx_in  = scan_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_frag_in = best_frag_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_in       = out_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty && out_free) begin
               q_pop                 = 1'b1;
               out_in                = '0;
               out_in.total_fragment = sum_ff;
               case (q_cmd.op)
                  fpfa_pkg::OP_LOAD: begin
                     out_valid_in = 1'b1;
                     if (count_ff == fpfa_pkg::CNT_W'(fpfa_pkg::BLOCKS)) begin
                        out_in.status = fpfa_pkg::STATUS_FULL;
                     end else begin
                        mem_we = 1'b1;
                        taken_in[count_ff[fpfa_pkg::IDX_W-1:0]] = 1'b0;
                        count_in = count_ff + 1'b1;
                        out_in.status      = fpfa_pkg::STATUS_LOADED;
                        out_in.block_index = fpfa_pkg::INDEX_W'(count_ff);
                     end
                  end
                  fpfa_pkg::OP_CLEAR: begin
                     out_valid_in          = 1'b1;
                     taken_in              = '0;
                     reqcnt_in             = '0;
                     sum_in                = '0;
                     out_in.status         = fpfa_pkg::STATUS_CLEARED;
                     out_in.total_fragment = '0;
                  end
                  fpfa_pkg::OP_REQUEST: begin
                     reqno_in    = reqcnt_ff;
                     reqcnt_in   = reqcnt_ff + 1'b1;
                     amount_in   = q_cmd.amount;
                     found_in    = 1'b0;
                     scan_idx_in = '0;
                     rd_addr     = '0;
                     if (count_ff == '0) begin
                        out_valid_in          = 1'b1;
                        out_in.status         = fpfa_pkg::STATUS_NO_FIT;
                        out_in.request_number = reqcnt_ff;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  default: begin
                     out_in = out_ff;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (cand_take) begin
               found_in     = 1'b1;
               best_idx_in  = scan_idx_ff;
               best_frag_in = cand_frag;
            end
            if (last_block || (cand_ok && first_fit)) begin
               state_in = ST_FINISH;
            end else begin
               scan_idx_in = scan_idx_ff + 1'b1;
               rd_addr     = scan_idx_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               out_valid_in          = 1'b1;
               out_in                = '0;
               out_in.request_number = reqno_ff;
               if (found_ff) begin
                  taken_in[best_idx_ff] = 1'b1;
                  sum_in                = sum_sat;
                  out_in.status         = fpfa_pkg::STATUS_ALLOCATED;
                  out_in.block_index    = fpfa_pkg::INDEX_W'(best_idx_ff);
                  out_in.fragment       = fpfa_pkg::FRAG_W'(best_frag_ff);
                  out_in.total_fragment = sum_sat;
               end else begin
                  out_in.status         = fpfa_pkg::STATUS_NO_FIT;
                  out_in.total_fragment = sum_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Block size table: one write port for loads, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[fpfa_pkg::IDX_W-1:0]] <= q_cmd.amount;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         taken_ff     <= '0;
         count_ff     <= '0;
         reqcnt_ff    <= '0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         taken_ff     <= taken_in;
         count_ff     <= count_in;
         reqcnt_ff    <= reqcnt_in;
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
      reqno_ff     <= reqno_in;
      amount_ff    <= amount_in;
      scan_idx_ff  <= scan_idx_in;
      found_ff     <= found_in;
      best_idx_ff  <= best_idx_in;
      best_frag_ff <= best_frag_in;
      out_ff       <= out_in;
   end

   assign rsp_ch.valid          = out_valid_ff;
   assign rsp_ch.status         = out_ff.status;
   assign rsp_ch.block_index    = out_ff.block_index;
   assign rsp_ch.fragment       = out_ff.fragment;
   assign rsp_ch.request_number = out_ff.request_number;
   assign rsp_ch.total_fragment = out_ff.total_fragment;

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench of the fixed-partition fit allocator
// Drives load, request, clear and unused-mode transfers into the core,
// predicts every result with a local model of the block table and the
// counters, and compares each result transfer field by field. The fit
// policy is reprogrammed over the CSR port between phases while idle.
// ----------------------------------------------------------------------------
module tb_top;
   import fpfa_pkg::*;

   // The fourth mode code is not decoded by the core and must be dropped.
   localparam logic [MODE_W-1:0]     MODE_UNUSED     = 2'd3;
   // The fourth policy code is not a policy of its own; it acts as first fit.
   localparam logic [POLICY_W-1:0]   POLICY_SPARE    = 2'd3;
   localparam logic [CSR_ADDR_W-1:0] FIT_POLICY_ADDR = {CSR_REG_FIT_POLICY, 2'b00};

   // A full-table request scan plus pipeline, with some margin.
   localparam int SETTLE_CYCLES = BLOCKS + 16;
   localparam int STALL_LIMIT   = 4000;
   localparam int PHASE_ITEMS   = 270;

   typedef struct packed {
      logic [MODE_W-1:0]   mode;
      logic [AMOUNT_W-1:0] amount;
   } alloc_cmd_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   fpfa_req_if req_ch ();
   fpfa_rsp_if rsp_ch ();

   fixed_partition_fit_allocator_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Commands waiting to be sent, and results the model says must come back.
   alloc_cmd_type       cmd_backlog[$];
   rsp_type             awaited_results[$];
   // Sizes of the loads issued so far, used to aim requests at exact fits.
   logic [AMOUNT_W-1:0] queued_sizes[$];

   // Local copy of the allocator state. Only loaded entries are ever read.
   logic [SIZE_WIDTH-1:0] partition_size[BLOCKS];
   bit                    partition_taken[BLOCKS];
   int                    partitions_loaded = 0;
   logic [REQNO_W-1:0]    request_seq = '0;
   logic [SUM_W-1:0]      waste_total = '0;
   logic [POLICY_W-1:0]   fit_mode = POLICY_FIRST;

   int transfers  = 0;
   int mismatches = 0;
   // Set for the final phase: no idle or stall bursts on either channel.
   bit calm       = 1'b0;

   int send_gap   = 0;
   int recv_stall = 0;

   // Clock with a period of 12 time units.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Computes the result that one accepted command must produce and updates
   // the local state. Returns zero for the unused mode, which yields nothing.
   function automatic bit predict_allocation(input logic [MODE_W-1:0] mode,
                                             input logic [AMOUNT_W-1:0] amount,
                                             output rsp_type outcome);
      bit                 found;
      int                 pick;
      logic [FRAG_W-1:0]  waste;
      logic [SUM_W:0]     sum;
      outcome = '0;
      case (mode)
         MODE_LOAD: begin
            if (partitions_loaded >= BLOCKS) begin
               outcome.status = STATUS_FULL;
            end else begin
               partition_size[partitions_loaded]  = amount;
               partition_taken[partitions_loaded] = 1'b0;
               outcome.status      = STATUS_LOADED;
               outcome.block_index = INDEX_W'(partitions_loaded);
               partitions_loaded++;
            end
         end
         MODE_REQUEST: begin
            outcome.request_number = request_seq;
            request_seq++;
            found = 1'b0;
            pick  = 0;
            // Strict comparisons keep ties on the lowest load index.
            for (int i = 0; i < partitions_loaded; i++) begin
               if (partition_taken[i] || partition_size[i] < amount) continue;
               if (!found) begin
                  found = 1'b1;
                  pick  = i;
                  if (fit_mode != POLICY_BEST && fit_mode != POLICY_WORST) break;
               end else if (fit_mode == POLICY_BEST &&
                            partition_size[i] < partition_size[pick]) begin
                  pick = i;
               end else if (fit_mode == POLICY_WORST &&
                            partition_size[i] > partition_size[pick]) begin
                  pick = i;
               end
            end
            if (!found) begin
               outcome.status = STATUS_NO_FIT;
            end else begin
               waste = partition_size[pick] - amount;
               sum   = {1'b0, waste_total} + waste;
               waste_total = (sum > SUM_MAX) ? SUM_MAX : sum[SUM_W-1:0];
               partition_taken[pick] = 1'b1;
               outcome.status      = STATUS_ALLOCATED;
               outcome.block_index = INDEX_W'(pick);
               outcome.fragment    = waste;
            end
         end
         MODE_CLEAR: begin
            for (int i = 0; i < BLOCKS; i++) partition_taken[i] = 1'b0;
            request_seq    = '0;
            waste_total    = '0;
            outcome.status = STATUS_CLEARED;
         end
         default: begin
            return 1'b0;
         end
      endcase
      outcome.total_fragment = waste_total;
      return 1'b1;
   endfunction

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want != got) begin
         mismatches++;
         $error("%s: expected %0d, actual %0d", name, want, got);
      end
   endtask

   // Driver. The model is advanced at the edge where a transfer happens, from
   // the payload on the bus, so the prediction follows exactly what the core
   // accepted. A new command is presented only when the slot is free, and
   // valid is written once per edge so back-to-back commands keep it high.
   always @(posedge clock) begin
      alloc_cmd_type next_cmd;
      rsp_type       outcome;
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            transfers++;
            if (predict_allocation(req_ch.mode, req_ch.amount, outcome))
               awaited_results.push_back(outcome);
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_ch.valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               next_cmd = cmd_backlog.pop_front();
               req_ch.mode   <= next_cmd.mode;
               req_ch.amount <= next_cmd.amount;
               req_ch.valid  <= 1'b1;
               if (!calm && $urandom_range(0, 11) == 0) send_gap = $urandom_range(1, 4);
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // Monitor. Each result transfer is matched against the oldest prediction;
   // ready is withdrawn in random bursts outside the final phase.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         recv_stall = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            transfers++;
            if (awaited_results.size() == 0) begin
               mismatches++;
               $error("result transfer with no prediction pending: status %0d",
                      rsp_ch.status);
            end else begin
               want = awaited_results.pop_front();
               check_field("status", want.status, rsp_ch.status);
               check_field("block_index", want.block_index, rsp_ch.block_index);
               check_field("fragment", want.fragment, rsp_ch.fragment);
               check_field("request_number", want.request_number, rsp_ch.request_number);
               check_field("total_fragment", want.total_fragment, rsp_ch.total_fragment);
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (!calm && $urandom_range(0, 9) == 0) recv_stall = $urandom_range(1, 4);
         end
      end
   end

   // Watchdog: a hang shows up as a long stretch with no transfer on either
   // channel, which also covers predictions that never get their result.
   initial begin
      int quiet_cycles;
      int seen;
      quiet_cycles = 0;
      seen         = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(negedge clock);
         if (transfers != seen) begin
            seen         = transfers;
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [AMOUNT_W-1:0] amount);
      cmd_backlog.push_back('{mode: mode, amount: amount});
      if (mode == MODE_LOAD && queued_sizes.size() < BLOCKS) queued_sizes.push_back(amount);
   endtask

   // Waits until every command has been accepted and every result has come
   // back, then lets a full scan's worth of cycles pass as margin; an unused-mode
   // command is dropped by the front when taken and leaves no result to wait for.
   task automatic drain_pipeline();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_ch.valid || awaited_results.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // APB write: setup cycle, then access cycle held until pready.
   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock);
      while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Policy changes happen only with the core idle; this is also where the
   // sender holds off until all outstanding results have arrived.
   task automatic set_policy(input logic [POLICY_W-1:0] policy);
      drain_pipeline();
      csr_write(FIT_POLICY_ADDR, CSR_DATA_W'(policy));
      fit_mode = policy;
   endtask

   // Random traffic. Loads are frequent until the table is full, then turn rare
   // so the table-full answer still shows up. Clears come often enough that
   // blocks are freed again, and some requests are aimed at sizes that
   // exist in the table so that grants under every policy are common.
   task automatic run_random_phase(input int count);
      int                  made;
      int                  roll;
      int                  shape;
      logic [AMOUNT_W-1:0] size;
      made = 0;
      while (made < count) begin
         roll  = $urandom_range(0, 99);
         shape = $urandom_range(0, 19);
         if (roll < 3) begin
            // Ignored by the core; it does not count toward the phase.
            queue_cmd(MODE_UNUSED, AMOUNT_W'($urandom));
         end else if (roll < 8) begin
            queue_cmd(MODE_CLEAR, AMOUNT_W'($urandom));
            made++;
         end else if (roll < ((queued_sizes.size() < BLOCKS) ? 40 : 11)) begin
            if (shape == 0) size = '1;
            else if (shape < 10) size = AMOUNT_W'($urandom_range(0, 4095));
            else size = AMOUNT_W'($urandom);
            queue_cmd(MODE_LOAD, size);
            made++;
         end else begin
            if (shape < 3) size = '0;
            else if (shape == 3) size = '1;
            else if (shape < 8 && queued_sizes.size() != 0)
               size = queued_sizes[$urandom_range(0, queued_sizes.size() - 1)];
            else if (shape < 14) size = AMOUNT_W'($urandom_range(0, 2047));
            else size = AMOUNT_W'($urandom);
            queue_cmd(MODE_REQUEST, size);
            made++;
         end
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      req_ch.valid  = 1'b0;
      req_ch.mode   = MODE_LOAD;
      req_ch.amount = '0;
      rsp_ch.ready  = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      set_policy(POLICY_FIRST);

      // Empty table: a request cannot fit, and an unused mode is dropped.
      queue_cmd(MODE_REQUEST, '0);
      queue_cmd(MODE_UNUSED, '1);

      // First fit: zero-sized block, exact fit, taken block, then a table
      // with a tie of equal sizes for the later policies.
      queue_cmd(MODE_LOAD, '0);
      queue_cmd(MODE_REQUEST, '0);
      queue_cmd(MODE_REQUEST, '0);
      queue_cmd(MODE_CLEAR, '0);
      queue_cmd(MODE_LOAD, '1);
      queue_cmd(MODE_LOAD, 16'd1000);
      queue_cmd(MODE_LOAD, 16'd1000);
      queue_cmd(MODE_LOAD, 16'd300);
      queue_cmd(MODE_REQUEST, '1);
      queue_cmd(MODE_REQUEST, 16'd500);
      queue_cmd(MODE_UNUSED, '0);
      queue_cmd(MODE_CLEAR, '1);

      // Best fit: smallest adequate block, then the tie goes to the lower index.
      set_policy(POLICY_BEST);
      queue_cmd(MODE_REQUEST, 16'd200);
      queue_cmd(MODE_REQUEST, 16'd900);
      queue_cmd(MODE_REQUEST, 16'd900);
      queue_cmd(MODE_REQUEST, '0);
      queue_cmd(MODE_CLEAR, '0);

      // Worst fit: the largest block first, then the equal pair in load order.
      set_policy(POLICY_WORST);
      queue_cmd(MODE_REQUEST, 16'd1);
      queue_cmd(MODE_REQUEST, 16'd2);
      queue_cmd(MODE_REQUEST, 16'd2);
      queue_cmd(MODE_CLEAR, '0);

      // The spare policy code must behave as first fit.
      set_policy(POLICY_SPARE);
      queue_cmd(MODE_REQUEST, 16'd1);
      queue_cmd(MODE_CLEAR, '0);

      set_policy(POLICY_WORST);
      run_random_phase(PHASE_ITEMS);
      set_policy(POLICY_FIRST);
      run_random_phase(PHASE_ITEMS);
      set_policy(POLICY_BEST);
      run_random_phase(PHASE_ITEMS);
      set_policy(POLICY_SPARE);
      run_random_phase(PHASE_ITEMS);
      set_policy(POLICY_WORST);
      run_random_phase(PHASE_ITEMS);
      set_policy(POLICY_BEST);
      run_random_phase(PHASE_ITEMS);

      // Final phase at full rate on both channels.
      set_policy(POLICY_FIRST);
      calm = 1'b1;
      run_random_phase(PHASE_ITEMS);

      drain_pipeline();
      if (mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// File: sim.f
design/fpfa_pkg.sv
design/fpfa_channels.sv
design/fpfa_front.sv
design/fpfa_queue.sv
design/fpfa_back.sv
design/fixed_partition_fit_allocator_core.sv
tb/tb_top.sv
